[hw/rtl/ppu_rv_pkg.sv]
// ppu_rv_pkg: shared types and constants for the ppu register / vram port
// used by the front and back modules and the top level
// no dependencies
package ppu_rv_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  // operation codes of an input word
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAM    = 3'd3;
  localparam logic [2:0] REG_UNUSED = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam int unsigned PATTERN_TABLE_BYTES = 4096;
  localparam int unsigned NAME_TABLE_BYTES    = 1024;
  localparam int unsigned PALETTE_BYTES       = 32;
  localparam int unsigned PAT_DEPTH           = 2 * PATTERN_TABLE_BYTES;
  localparam int unsigned NT_BANKS            = 4;

  localparam logic [14:0] VRAM_MASK     = 15'h7FFF;
  localparam logic [15:0] VRAM_LIMIT    = 16'h3FFF;
  localparam logic [5:0]  PAL_PAGE      = 6'h3F;
  localparam logic [4:0]  NT_TOP_PAGE   = 5'h1F;
  localparam logic [4:0]  PAL_MIRROR    = 5'h10;
  localparam logic [14:0] ROW_STEP      = 15'h0020;

  localparam logic [8:0] DOTS_LAST     = 9'd340;
  localparam logic [8:0] LINE_LAST     = 9'd261;
  localparam logic [8:0] LINE_PRE      = 9'h1FF;
  localparam logic [8:0] LINE_VBLANK   = 9'd241;
  localparam logic [8:0] DOT_FLAG      = 9'd1;

  localparam int unsigned CTRL_INC_BIT = 2;
  localparam int unsigned CTRL_NMI_BIT = 7;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       tick;
    logic [2:0] reg_index;
    logic [7:0] wdata;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       error;
    logic       nmi;
  } result_t;

endpackage

[hw/rtl/ppu_rv_if.sv]
// ppu_rv_in_if / ppu_rv_out_if: valid/ready channels of the port
// input words and result words; no dependencies
interface ppu_rv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] reg_index;
  logic [7:0] wdata;
  modport source (output valid, op, reg_index, wdata, input ready);
  modport sink (input valid, op, reg_index, wdata, output ready);
endinterface

interface ppu_rv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       error;
  logic       nmi;
  modport source (output valid, rdata, error, nmi, input ready);
  modport sink (input valid, rdata, error, nmi, output ready);
endinterface

[hw/rtl/ppu_register_vram_port_top.sv]
// ppu_register_vram_port_top: cpu-side register and vram port of a tile video unit
// depends on ppu_rv_pkg, ppu_rv_if, ppu_rv_front and ppu_rv_back
//
//   channel  | dir | handshake        | word
//   in_ch    | in  | valid/ready      | op, reg_index, wdata
//   out_ch   | out | valid/ready      | rdata, error, nmi
//   apb      | in  | psel/penable     | mirror_vertical at addresses 0 to 3 (paddr[2] low)
//
// one word per cycle sustained while out_ch is ready; a word goes from its queue slot
// through the execute stage that owns the single vram port into the output register
// reset is synchronous and clears all control state; pattern and name-table contents stay unknown
// a stalled result holds in the output register while the queue still takes words until it is full
module ppu_register_vram_port_top #(
  parameter int unsigned QDEPTH = ppu_rv_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  ppu_rv_in_if.sink    in_ch,
  ppu_rv_out_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic mirror_r;
  logic q_valid, q_ready;
  ppu_rv_pkg::item_t q_item;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {31'h0, mirror_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mirror_r <= pwdata[0];
    end
  end

  ppu_rv_front #(.QDEPTH(QDEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  ppu_rv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mirror_vertical (mirror_r),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_ch          (out_ch)
  );

endmodule

[hw/rtl/ppu_rv_front.sv]
// ppu_rv_front: accepts input words, decodes the op and queues them
// depends on ppu_rv_pkg and ppu_rv_in_if
module ppu_rv_front #(
  parameter int unsigned QDEPTH = ppu_rv_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  ppu_rv_in_if.sink           in_ch,
  output logic                q_valid,
  input  logic                q_ready,
  output ppu_rv_pkg::item_t   q_item
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  ppu_rv_pkg::item_t slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic push, pop;
  ppu_rv_pkg::item_t dec;

  always_comb begin
    dec.rd        = (in_ch.op == ppu_rv_pkg::OP_READ);
    dec.wr        = (in_ch.op == ppu_rv_pkg::OP_WRITE);
    dec.tick      = (in_ch.op == ppu_rv_pkg::OP_TICK);
    dec.reg_index = in_ch.reg_index;
    dec.wdata     = in_ch.wdata;
  end

  assign in_ch.ready = (cnt_r != CW'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/ppu_rv_back.sv]
// ppu_rv_back: executes queued words against registers and vram, holds the result
// depends on ppu_rv_pkg and ppu_rv_out_if
module ppu_rv_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mirror_vertical,
  input  logic               q_valid,
  output logic               q_ready,
  input  ppu_rv_pkg::item_t  q_item,
  ppu_rv_out_if.source       out_ch
);

  localparam int unsigned NTW = $clog2(ppu_rv_pkg::NAME_TABLE_BYTES);
  localparam int unsigned PTW = $clog2(ppu_rv_pkg::PAT_DEPTH);

  logic [7:0]  ctrl_r, ctrl_nxt, mask_r, mask_nxt, oam_r, oam_nxt;
  logic [7:0]  scroll_h_r, scroll_h_nxt, scroll_v_r, scroll_v_nxt;
  logic [14:0] vram_r, vram_nxt;
  logic        toggle_r, toggle_nxt;
  logic [4:0]  low_r, low_nxt;
  logic        vblank_r, vblank_nxt;
  logic        stat_pend_r, stat_pend_nxt, data_pend_r, data_pend_nxt;
  logic [8:0]  dot_r, dot_nxt, line_r, line_nxt;
  logic [5:0]  pal_r [ppu_rv_pkg::PALETTE_BYTES];

  logic        out_valid_r;
  ppu_rv_pkg::result_t res_r, res_nxt;

  // read buffer is the registered output of the last pattern or name-table read
  logic [7:0]  pat_mem [ppu_rv_pkg::PAT_DEPTH];
  logic [7:0]  pat_dout_r;
  logic [7:0]  nt_dout_r [ppu_rv_pkg::NT_BANKS];
  logic        src_pat_r, buf_zero_r;
  logic [1:0]  src_q_r;
  logic [7:0]  rbuf;

  logic        go;
  logic        in_pat, in_nt, in_pal;
  logic [1:0]  q, partner;
  logic        pat_we, pat_re, nt_re, pal_we, pal_we2;
  logic [ppu_rv_pkg::NT_BANKS-1:0] nt_we;
  logic [4:0]  pal_idx;
  logic [15:0] addr_sum;

  assign q_ready = !out_valid_r || out_ch.ready;
  assign go      = q_valid && q_ready;

  assign in_pat  = (vram_r[14:13] == 2'b00);
  assign in_nt   = !vram_r[14] && vram_r[13] && (vram_r[12:8] != ppu_rv_pkg::NT_TOP_PAGE);
  assign in_pal  = !vram_r[14] && (vram_r[13:8] == ppu_rv_pkg::PAL_PAGE);
  assign q       = vram_r[11:10];
  assign partner = mirror_vertical ? (q ^ 2'b10) : (q ^ 2'b01);
  assign pal_idx = vram_r[4:0];
  assign rbuf    = buf_zero_r ? 8'h00 : (src_pat_r ? pat_dout_r : nt_dout_r[src_q_r]);
  assign addr_sum = {1'b0, vram_r} + {8'h00, q_item.wdata};

  always_comb begin
    ctrl_nxt      = ctrl_r;
    mask_nxt      = mask_r;
    oam_nxt       = oam_r;
    scroll_h_nxt  = scroll_h_r;
    scroll_v_nxt  = scroll_v_r;
    vram_nxt      = vram_r;
    toggle_nxt    = toggle_r;
    low_nxt       = low_r;
    vblank_nxt    = vblank_r;
    stat_pend_nxt = stat_pend_r;
    data_pend_nxt = data_pend_r;
    dot_nxt       = dot_r;
    line_nxt      = line_r;
    res_nxt       = '0;
    pat_we        = 1'b0;
    pat_re        = 1'b0;
    nt_re         = 1'b0;
    nt_we         = '0;
    pal_we        = 1'b0;
    pal_we2       = 1'b0;

    if (q_item.rd) begin
      unique case (q_item.reg_index) inside
        ppu_rv_pkg::REG_CTRL:   res_nxt.rdata = ctrl_r;
        ppu_rv_pkg::REG_MASK:   res_nxt.rdata = mask_r;
        ppu_rv_pkg::REG_STATUS: begin
          stat_pend_nxt = 1'b1;
          res_nxt.rdata = {vblank_r, 2'b00, low_r};
        end
        ppu_rv_pkg::REG_OAM:    res_nxt.rdata = oam_r;
        ppu_rv_pkg::REG_SCROLL, ppu_rv_pkg::REG_ADDR: res_nxt.rdata = 8'h00;
        ppu_rv_pkg::REG_DATA: begin
          data_pend_nxt = 1'b1;
          if (in_pat || in_nt) begin
            res_nxt.rdata = rbuf;
            pat_re        = in_pat;
            nt_re         = in_nt;
          end else if (in_pal) begin
            res_nxt.rdata = {2'b00, pal_r[pal_idx]};
          end else begin
            res_nxt.error = 1'b1;
          end
        end
        default: res_nxt.error = 1'b1;
      endcase
    end else if (q_item.wr) begin
      low_nxt = q_item.wdata[4:0];
      unique case (q_item.reg_index)
        ppu_rv_pkg::REG_CTRL: ctrl_nxt = q_item.wdata;
        ppu_rv_pkg::REG_MASK: mask_nxt = q_item.wdata;
        ppu_rv_pkg::REG_OAM:  oam_nxt  = q_item.wdata;
        ppu_rv_pkg::REG_SCROLL: begin
          if (toggle_r) begin
            scroll_v_nxt = q_item.wdata;
          end else begin
            scroll_h_nxt = q_item.wdata;
          end
          toggle_nxt = !toggle_r;
        end
        ppu_rv_pkg::REG_ADDR: begin
          toggle_nxt = !toggle_r;
          if (toggle_r) begin
            res_nxt.error = (addr_sum > ppu_rv_pkg::VRAM_LIMIT);
            vram_nxt      = addr_sum[14:0];
          end else begin
            // high byte lands in bits 14..8, bit 15 falls off
            res_nxt.error = (q_item.wdata[7:6] != 2'b00);
            vram_nxt      = {q_item.wdata[6:0], 8'h00};
          end
        end
        ppu_rv_pkg::REG_DATA: begin
          data_pend_nxt = 1'b1;
          if (in_pat) begin
            pat_we = 1'b1;
          end else if (in_nt) begin
            nt_we[q]       = 1'b1;
            nt_we[partner] = 1'b1;
          end else if (in_pal) begin
            pal_we  = 1'b1;
            pal_we2 = (vram_r[1:0] == 2'b00);
          end else begin
            res_nxt.error = 1'b1;
          end
        end
        default: begin
          res_nxt.error = 1'b1;
          low_nxt       = low_r;
        end
      endcase
    end else if (q_item.tick) begin
      if (stat_pend_r) begin
        stat_pend_nxt = 1'b0;
        vblank_nxt    = 1'b0;
        toggle_nxt    = 1'b0;
      end
      if (data_pend_r) begin
        data_pend_nxt = 1'b0;
        vram_nxt = (vram_r + (ctrl_r[ppu_rv_pkg::CTRL_INC_BIT] ? ppu_rv_pkg::ROW_STEP
                                                                 : 15'd1))
                   & ppu_rv_pkg::VRAM_MASK;
      end
      if (line_r == ppu_rv_pkg::LINE_PRE && dot_r == ppu_rv_pkg::DOT_FLAG) begin
        vblank_nxt = 1'b0;
      end else if (line_r == ppu_rv_pkg::LINE_VBLANK && dot_r == ppu_rv_pkg::DOT_FLAG) begin
        vblank_nxt  = 1'b1;
        res_nxt.nmi = ctrl_r[ppu_rv_pkg::CTRL_NMI_BIT];
      end
      if (dot_r == ppu_rv_pkg::DOTS_LAST) begin
        dot_nxt  = '0;
        line_nxt = (line_r == ppu_rv_pkg::LINE_LAST) ? ppu_rv_pkg::LINE_PRE : line_r + 1'b1;
      end else begin
        dot_nxt = dot_r + 1'b1;
      end
    end
  end

  // pattern memory
  always_ff @(posedge clk) begin
    if (go && pat_we) begin
      pat_mem[vram_r[PTW-1:0]] <= q_item.wdata;
    end
    if (go && pat_re) begin
      pat_dout_r <= pat_mem[vram_r[PTW-1:0]];
    end
  end

  // name-table banks, one per quarter so a mirrored write lands in both quarters in the same cycle
  for (genvar b = 0; b < ppu_rv_pkg::NT_BANKS; b++) begin : g_nt
    logic [7:0] bank_mem [ppu_rv_pkg::NAME_TABLE_BYTES];
    always_ff @(posedge clk) begin
      if (go && nt_we[b]) begin
        bank_mem[vram_r[NTW-1:0]] <= q_item.wdata;
      end
      if (go && nt_re) begin
        nt_dout_r[b] <= bank_mem[vram_r[NTW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      mask_r      <= '0;
      oam_r       <= '0;
      scroll_h_r  <= '0;
      scroll_v_r  <= '0;
      vram_r      <= '0;
      toggle_r    <= 1'b0;
      low_r       <= '0;
      vblank_r    <= 1'b0;
      stat_pend_r <= 1'b0;
      data_pend_r <= 1'b0;
      dot_r       <= '0;
      line_r      <= ppu_rv_pkg::LINE_PRE;
      src_pat_r   <= 1'b0;
      src_q_r     <= '0;
      buf_zero_r  <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ppu_rv_pkg::PALETTE_BYTES; i++) begin
        pal_r[i] <= '0;
      end
    end else begin
      if (go) begin
        ctrl_r      <= ctrl_nxt;
        mask_r      <= mask_nxt;
        oam_r       <= oam_nxt;
        scroll_h_r  <= scroll_h_nxt;
        scroll_v_r  <= scroll_v_nxt;
        vram_r      <= vram_nxt;
        toggle_r    <= toggle_nxt;
        low_r       <= low_nxt;
        vblank_r    <= vblank_nxt;
        stat_pend_r <= stat_pend_nxt;
        data_pend_r <= data_pend_nxt;
        dot_r       <= dot_nxt;
        line_r      <= line_nxt;
        if (pat_re || nt_re) begin
          src_pat_r  <= pat_re;
          src_q_r    <= q;
          buf_zero_r <= 1'b0;
        end
        if (pal_we) begin
          pal_r[pal_idx] <= q_item.wdata[5:0];
        end
        if (pal_we2) begin
          pal_r[pal_idx ^ ppu_rv_pkg::PAL_MIRROR] <= q_item.wdata[5:0];
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.rdata = res_r.rdata;
  assign out_ch.error = res_r.error;
  assign out_ch.nmi   = res_r.nmi;

endmodule
